FILE: rtl/cfs_pkg.sv
// Shared types, operation codes and widths for the constant folding stream.
package cfs_pkg;
    localparam int unsigned REGS_DEF = 64;
    localparam int unsigned REG_FIELD_W = 7;
    localparam int unsigned VAL_W = 64;
    localparam int unsigned FUNC_W = 5;

    localparam logic [FUNC_W-1:0] OP_LABEL = 5'd0;
    localparam logic [FUNC_W-1:0] OP_IMM   = 5'd1;
    localparam logic [FUNC_W-1:0] OP_ADD   = 5'd2;
    localparam logic [FUNC_W-1:0] OP_SUB   = 5'd3;
    localparam logic [FUNC_W-1:0] OP_MUL   = 5'd4;
    localparam logic [FUNC_W-1:0] OP_DIV   = 5'd5;
    localparam logic [FUNC_W-1:0] OP_MOD   = 5'd6;
    localparam logic [FUNC_W-1:0] OP_AND   = 5'd7;
    localparam logic [FUNC_W-1:0] OP_OR    = 5'd8;
    localparam logic [FUNC_W-1:0] OP_XOR   = 5'd9;
    localparam logic [FUNC_W-1:0] OP_SHL   = 5'd10;
    localparam logic [FUNC_W-1:0] OP_SHR   = 5'd11;
    localparam logic [FUNC_W-1:0] OP_EQ    = 5'd12;
    localparam logic [FUNC_W-1:0] OP_NE    = 5'd13;
    localparam logic [FUNC_W-1:0] OP_LT    = 5'd14;
    localparam logic [FUNC_W-1:0] OP_LE    = 5'd15;
    localparam logic [FUNC_W-1:0] OP_GT    = 5'd16;
    localparam logic [FUNC_W-1:0] OP_GE    = 5'd17;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input, start table read
        logic clear;      // label: drop all marks
        logic exec;       // evaluate operands (after table read)
        logic mul_step;   // next partial product
        logic div_start;
        logic finish;     // form result, write table, load output
    } cfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_label;
        logic is_imm;
        logic foldable;   // both sources known, op foldable
        logic is_mul;
        logic is_div;
        logic mul_last;
        logic div_done;
    } cfs_stat_t;
endpackage

FILE: rtl/cfs_div.sv
// Radix-2 restoring divider for signed 64-bit div and mod.
module cfs_div
    import cfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] dividend,
    input  logic [VAL_W-1:0] divisor,
    output logic             done,
    output logic [VAL_W-1:0] quot,
    output logic [VAL_W-1:0] rem
);
    localparam int unsigned CNT_W = $clog2(VAL_W + 1);

    logic [VAL_W-1:0] q_reg, q_next;
    logic [VAL_W-1:0] r_reg, r_next;
    logic [VAL_W-1:0] d_reg, d_next;
    logic             qneg_reg, qneg_next;
    logic             rneg_reg, rneg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VAL_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[VAL_W-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend[VAL_W-1] ? (~dividend + 1'b1) : dividend;
            d_next    = divisor[VAL_W-1] ? (~divisor + 1'b1) : divisor;
            r_next    = '0;
            qneg_next = dividend[VAL_W-1] ^ divisor[VAL_W-1];
            rneg_next = dividend[VAL_W-1];
            cnt_next  = CNT_W'(VAL_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[VAL_W])
            begin
                r_next = {r_reg[VAL_W-2:0], q_reg[VAL_W-1]};
                q_next = {q_reg[VAL_W-2:0], 1'b0};
            end
            else
            begin
                r_next = trial[VAL_W-1:0];
                q_next = {q_reg[VAL_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done = done_reg;
    assign quot = qneg_reg ? (~q_reg + 1'b1) : q_reg;
    assign rem  = rneg_reg ? (~r_reg + 1'b1) : r_reg;
endmodule

FILE: rtl/cfs_datapath.sv
// Constant table, operand evaluation, multiplier and result register.
module cfs_datapath
    import cfs_pkg::*;
#(
    parameter int unsigned REGS = REGS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfs_cmd_t               cmd,
    output cfs_stat_t              stat,
    input  logic [25:0]            in_data,
    input  logic [VAL_W-1:0]       in_imm,
    output logic                   res_folded,
    output logic [FUNC_W-1:0]      res_func,
    output logic [VAL_W-1:0]       res_value
);
    // only non-negative register numbers of the signed field can be addressed
    localparam int unsigned MAX_TBL = 1 << (REG_FIELD_W - 1);
    localparam int unsigned TBL_N   = (REGS < MAX_TBL) ? REGS : MAX_TBL;
    localparam int unsigned IDX_W   = (TBL_N > 1) ? $clog2(TBL_N) : 1;

    logic [VAL_W-1:0] values_mem [TBL_N];
    logic [TBL_N-1:0] flags_reg;

    logic [FUNC_W-1:0]      func_reg;
    logic [REG_FIELD_W-1:0] dst_reg, s1_reg, s2_reg;
    logic [VAL_W-1:0]       imm_reg;
    logic [VAL_W-1:0]       a_reg, b_reg;
    logic                   k1_reg, k2_reg;
    logic [VAL_W-1:0]       res_reg;
    logic                   fold_reg;
    logic [VAL_W-1:0]       acc_reg;
    logic [1:0]             mstep_reg;
    logic [VAL_W-1:0]       alu;
    logic                   alu_ok;
    logic                   d_ok, s1_ok, s2_ok;
    logic                   div_done;
    logic [VAL_W-1:0]       quot, rem;
    logic                   lt_ab, lt_ba;
    logic [5:0]             sh;
    logic [63:0]            mprod;
    logic                   fold_now;
    logic [VAL_W-1:0]       wval;

    function automatic logic in_range(input logic [REG_FIELD_W-1:0] r);
        return !r[REG_FIELD_W-1] && ({25'd0, r} < 32'(REGS));
    endfunction

    assign d_ok  = in_range(dst_reg);
    assign s1_ok = in_range(s1_reg);
    assign s2_ok = in_range(s2_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_data[FUNC_W-1:0];
            dst_reg  <= in_data[11:5];
            s1_reg   <= in_data[18:12];
            s2_reg   <= in_data[25:19];
            imm_reg  <= in_imm;
        end
    end

    // table read, registered
    always_ff @(posedge clk)
    begin
        a_reg <= values_mem[s1_reg[IDX_W-1:0]];
        b_reg <= values_mem[s2_reg[IDX_W-1:0]];
        k1_reg <= s1_ok && flags_reg[s1_reg[IDX_W-1:0]];
        k2_reg <= s2_ok && flags_reg[s2_reg[IDX_W-1:0]];
    end

    cfs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    // 64x64 low product over three 32x32 partial products
    always_comb
    begin
        case (mstep_reg)
            2'd0:    mprod = {32'd0, a_reg[31:0]} * {32'd0, b_reg[31:0]};
            2'd1:    mprod = {a_reg[31:0] * b_reg[63:32], 32'd0};
            2'd2:    mprod = {a_reg[63:32] * b_reg[31:0], 32'd0};
            default: mprod = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mstep_reg <= '0;
        else if (cmd.exec)
            mstep_reg <= '0;
        else if (cmd.mul_step)
            mstep_reg <= mstep_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
            acc_reg <= '0;
        else if (cmd.mul_step)
            acc_reg <= acc_reg + mprod;
    end

    assign lt_ab = $signed(a_reg) < $signed(b_reg);
    assign lt_ba = $signed(b_reg) < $signed(a_reg);
    assign sh    = b_reg[5:0];

    always_comb
    begin
        alu    = '0;
        alu_ok = 1'b1;
        case (func_reg)
            OP_ADD: alu = a_reg + b_reg;
            OP_SUB: alu = a_reg - b_reg;
            OP_MUL: alu = acc_reg;
            OP_DIV:
            begin
                alu    = (b_reg == '1) ? (~a_reg + 1'b1) : quot;
                alu_ok = (b_reg != '0);
            end
            OP_MOD:
            begin
                alu    = (b_reg == '1) ? '0 : rem;
                alu_ok = (b_reg != '0);
            end
            OP_AND: alu = a_reg & b_reg;
            OP_OR:  alu = a_reg | b_reg;
            OP_XOR: alu = a_reg ^ b_reg;
            OP_SHL: alu = a_reg << sh;
            OP_SHR: alu = $unsigned($signed(a_reg) >>> sh);
            OP_EQ:  alu = VAL_W'(a_reg == b_reg);
            OP_NE:  alu = VAL_W'(a_reg != b_reg);
            OP_LT:  alu = VAL_W'(lt_ab);
            OP_LE:  alu = VAL_W'(!lt_ba);
            OP_GT:  alu = VAL_W'(lt_ba);
            OP_GE:  alu = VAL_W'(!lt_ab);
            default: alu_ok = 1'b0;
        endcase
    end

    assign stat.is_label = (func_reg == OP_LABEL);
    assign stat.is_imm   = (func_reg == OP_IMM);
    assign stat.foldable = k1_reg && k2_reg && (func_reg >= OP_ADD) && (func_reg <= OP_GE)
                           && !(((func_reg == OP_DIV) || (func_reg == OP_MOD))
                                && (b_reg == '0));
    assign stat.is_mul   = (func_reg == OP_MUL);
    assign stat.is_div   = (func_reg == OP_DIV) || (func_reg == OP_MOD);
    assign stat.mul_last = (mstep_reg == 2'd2);
    assign stat.div_done = div_done;

    assign fold_now = !stat.is_label && !stat.is_imm && stat.foldable && alu_ok;
    assign wval     = stat.is_imm ? imm_reg : alu;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else if (cmd.clear)
            flags_reg <= '0;
        else if (cmd.finish && (stat.is_imm || fold_now) && d_ok)
            flags_reg[dst_reg[IDX_W-1:0]] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && !stat.is_label && (stat.is_imm || fold_now) && d_ok)
            values_mem[dst_reg[IDX_W-1:0]] <= wval;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            fold_reg <= fold_now;
            res_reg  <= fold_now ? alu : imm_reg;
        end
    end

    assign res_folded = fold_reg;
    assign res_func   = fold_reg ? OP_IMM : func_reg;
    assign res_value  = res_reg;
endmodule

FILE: rtl/cfs_ctrl.sv
// Sequencer: accept, table read, evaluate, optional multiply or divide, finish, output.
module cfs_ctrl
    import cfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output cfs_cmd_t  cmd,
    input  cfs_stat_t stat
);
    typedef enum logic [2:0] {IDLE, READ, EVAL, MUL, DIV, FIN, OUT} state_t;
    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == IDLE);
        out_valid  = (state_reg == OUT);
        case (state_reg)
            IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = READ;
                end
            READ: state_next = EVAL;
            EVAL:
            begin
                cmd.exec = 1'b1;
                cmd.clear = stat.is_label;
                if (stat.foldable && stat.is_mul)
                    state_next = MUL;
                else if (stat.foldable && stat.is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = DIV;
                end
                else
                    state_next = FIN;
            end
            MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                    state_next = FIN;
            end
            DIV:
                if (stat.div_done)
                    state_next = FIN;
            FIN:
            begin
                cmd.finish = 1'b1;
                state_next = OUT;
            end
            OUT:
                if (out_ready)
                    state_next = IDLE;
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE;
        else
            state_reg <= state_next;
    end
endmodule

FILE: rtl/constant_folding_stream.sv
// Top level of the constant folding stream block.
// One instruction per transaction; one result per instruction. A result is
// valid once its instruction has passed the table read, evaluate and finish
// steps; a folded mul also steps through its partial products, and a folded div
// or mod also waits for the bit-serial divider. The next instruction is taken the
// cycle after the result has been handed off, so a new instruction is never
// accepted while the previous one is still in flight.
module constant_folding_stream
    import cfs_pkg::*;
#(
    parameter int unsigned REGS = REGS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // func[4:0], dest_reg[11:5], src1_reg[18:12],
                                        // src2_reg[25:19], imm_value[89:26]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // folded[0], out_func[5:1], out_value[69:6]
);
    cfs_cmd_t  cmd;
    cfs_stat_t stat;
    logic                  folded;
    logic [FUNC_W-1:0]     ofunc;
    logic [VAL_W-1:0]      oval;
    logic [25:0]           hdr;

    // fields total 90 bits; tdata is padded to 96 bits
    assign hdr = s_axis_tdata[25:0];

    cfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    cfs_datapath #(.REGS(REGS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (hdr),
        .in_imm     (s_axis_tdata[89:26]),
        .res_folded (folded),
        .res_func   (ofunc),
        .res_value  (oval)
    );

    assign m_axis_tdata = {2'b00, oval, ofunc, folded};
endmodule
